/* rtl/core/alrp_pkg.sv */
// ----------------------------------------------------------------------------
// alrp_pkg
// Shared constants, codes and types for the arc-length reparameterization
// block: field widths, register map, command codes and unit opcodes.
// ----------------------------------------------------------------------------
package alrp_pkg;

    // Default sizing of the length table
    localparam int MAX_ENTRIES_DEF = 256;
    localparam int LENGTH_BITS_DEF = 32;

    // Fixed field widths
    localparam int CMD_W       = 1;
    localparam int ENTRY_IDX_W = 8;
    localparam int ENTRY_LEN_W = 32;
    localparam int POS_W       = 17;
    localparam int FRAC_BITS   = 16;
    localparam int DIVISIONS_W = 8;
    localparam int TOL_W       = 16;

    // Q1.16 value of 1.0
    localparam logic [POS_W-1:0] ONE_Q16 = 17'h10000;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
    localparam logic [CMD_W-1:0] CMD_MAP  = 1'b1;

    // Register map (byte address = 4 * index)
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int ADDR_LSB = 2;
    localparam logic REG_DIVISIONS = 1'b0;
    localparam logic REG_TOLERANCE = 1'b1;

    // Register reset values
    localparam logic [DIVISIONS_W-1:0] DIVISIONS_RST = 8'd200;
    localparam logic [TOL_W-1:0]       TOL_RST       = 16'd1;

    // Shared add/subtract unit opcodes
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    // Iteration counts of the serial loops
    localparam int STEP_W     = 5;
    localparam int MUL_STEPS  = POS_W;
    localparam int FDIV_STEPS = FRAC_BITS;
    localparam int QDIV_STEPS = POS_W;

    // Configuration seen by the sequencer
    typedef struct packed {
        logic [DIVISIONS_W-1:0] divisions;
        logic [TOL_W-1:0]       match_tolerance;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic [POS_W-1:0] curve_param;
        logic             exact_hit;
    } res_t;

    // Sequencer status toward the top level
    typedef struct packed {
        logic idle;
        logic done;
    } seq_status_t;

endpackage

/* rtl/core/alrp_ifs.sv */
// ----------------------------------------------------------------------------
// alrp_ifs
// Valid/ready stream interfaces: command items in, result items out.
// ----------------------------------------------------------------------------
interface alrp_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [alrp_pkg::CMD_W-1:0]          command;
    logic [alrp_pkg::ENTRY_IDX_W-1:0]    entry_index;
    logic [alrp_pkg::ENTRY_LEN_W-1:0]    entry_length;
    logic [alrp_pkg::POS_W-1:0]          position;

    modport source (
        output valid, command, entry_index, entry_length, position,
        input  ready
    );
    modport sink (
        input  valid, command, entry_index, entry_length, position,
        output ready
    );
endinterface

interface alrp_res_if;
    logic                        valid;
    logic                        ready;
    logic [alrp_pkg::POS_W-1:0]  curve_param;
    logic                        exact_hit;

    modport source (
        output valid, curve_param, exact_hit,
        input  ready
    );
    modport sink (
        input  valid, curve_param, exact_hit,
        output ready
    );
endinterface

/* rtl/core/arc_length_reparameterize.sv */
// ----------------------------------------------------------------------------
// arc_length_reparameterize
// Maps a normalized arc-length position to a curve parameter through a
// table of cumulative arc lengths.
// ----------------------------------------------------------------------------
// Usage:
//   cmd    : valid/ready stream. command LOAD writes entry_length into table
//            entry entry_index (indices past the table are dropped) and gives
//            no result. command MAP starts a query with position.
//   result : valid/ready stream, one transfer per MAP command carrying
//            curve_param (Q1.16) and exact_hit.
//   APB    : divisions at 0x0, match_tolerance at 0x4; write only while the
//            block is idle.
// Occupancy: a LOAD leaves the sequencer idle. A MAP holds cmd.ready low
//   until its result is handed to the output register; the binary search
//   makes at most ceil(log2(d+2)) table probes, and a target inside a segment
//   adds the segment fraction divide. All of it runs on the one shared adder:
//   17 shift-add steps for the scaling, table probes on the RAM read port,
//   16 steps for the segment fraction and 17 steps for the final divide.
// Reset: clears the sequencer and the output register; registers return to
//   divisions = 200, match_tolerance = 1. Table contents stay undefined
//   until loaded.
// Stall: a finished result waits in the output register; the next command is
//   still taken, and a further result waits in the sequencer until the
//   output register frees.
// ----------------------------------------------------------------------------
module arc_length_reparameterize #(
    parameter int MAX_ENTRIES = alrp_pkg::MAX_ENTRIES_DEF,
    parameter int LENGTH_BITS = alrp_pkg::LENGTH_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [alrp_pkg::PADDR_W-1:0]   paddr,
    input  logic [alrp_pkg::PDATA_W-1:0]   pwdata,
    output logic [alrp_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    alrp_cmd_if.sink                       cmd,
    alrp_res_if.source                     result
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);

    alrp_pkg::cfg_t        cfg;
    alrp_pkg::seq_status_t seq_status;
    alrp_pkg::res_t        seq_res;

    logic                   cmd_xfer;
    logic                   load_we;
    logic                   query_start;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [LENGTH_BITS-1:0] rd_data;
    logic                   res_ack;
    logic                   out_valid_reg, out_valid_next;
    alrp_pkg::res_t         out_res_reg;

    alrp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Command transfer decode
    assign cmd.ready   = seq_status.idle;
    assign cmd_xfer    = cmd.valid && cmd.ready;
    assign load_we     = cmd_xfer && (cmd.command == alrp_pkg::CMD_LOAD)
                         && (32'(cmd.entry_index) < 32'(MAX_ENTRIES));
    assign query_start = cmd_xfer && (cmd.command == alrp_pkg::CMD_MAP);

    alrp_ram #(
        .WIDTH (LENGTH_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (IDX_W'(cmd.entry_index)),
        .wdata (LENGTH_BITS'(cmd.entry_length)),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    alrp_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (query_start),
        .position (cmd.position),
        .cfg      (cfg),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .status   (seq_status),
        .res      (seq_res),
        .res_ack  (res_ack)
    );

    // Output register: takes a result when empty or being drained
    assign res_ack = seq_status.done && (!out_valid_reg || result.ready);

    always_comb
    begin
        if (res_ack)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            out_res_reg <= seq_res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.curve_param = out_res_reg.curve_param;
    assign result.exact_hit   = out_res_reg.exact_hit;

endmodule

/* rtl/core/alrp_ram.sv */
// ----------------------------------------------------------------------------
// alrp_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module alrp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/alrp_alu.sv */
// ----------------------------------------------------------------------------
// alrp_alu
// Shared add/subtract unit. The top bit of the result is the sign of a
// difference when both operands stay below half the range.
// ----------------------------------------------------------------------------
module alrp_alu #(
    parameter int W = 34
) (
    input  logic         op,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] sum,
    output logic         neg,
    output logic         zero
);

    logic [W-1:0] b_eff;

    // Two's complement subtract reuses the adder
    always_comb
    begin
        b_eff = (op == alrp_pkg::ALU_SUB) ? ~b : b;
        sum   = a + b_eff + W'(op == alrp_pkg::ALU_SUB);
        neg   = sum[W-1];
        zero  = (sum == '0);
    end

endmodule

/* rtl/core/alrp_regs.sv */
// ----------------------------------------------------------------------------
// alrp_regs
// APB configuration registers: division count and exact-match tolerance.
// ----------------------------------------------------------------------------
module alrp_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [alrp_pkg::PADDR_W-1:0]   paddr,
    input  logic [alrp_pkg::PDATA_W-1:0]   pwdata,
    output logic [alrp_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output alrp_pkg::cfg_t                 cfg
);

    logic [alrp_pkg::DIVISIONS_W-1:0] divisions_reg;
    logic [alrp_pkg::TOL_W-1:0]       tolerance_reg;
    logic                             wr_en;
    logic                             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[alrp_pkg::ADDR_LSB];

    // Register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisions_reg <= alrp_pkg::DIVISIONS_RST;
            tolerance_reg <= alrp_pkg::TOL_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                alrp_pkg::REG_DIVISIONS: divisions_reg <= pwdata[alrp_pkg::DIVISIONS_W-1:0];
                alrp_pkg::REG_TOLERANCE: tolerance_reg <= pwdata[alrp_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_sel)
            alrp_pkg::REG_DIVISIONS: prdata = alrp_pkg::PDATA_W'(divisions_reg);
            alrp_pkg::REG_TOLERANCE: prdata = alrp_pkg::PDATA_W'(tolerance_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.divisions       = divisions_reg;
    assign cfg.match_tolerance = tolerance_reg;

endmodule

/* rtl/core/alrp_seq.sv */
// ----------------------------------------------------------------------------
// alrp_seq
// Query sequencer: shift-add scaling of the position, binary search over the
// length table, tolerance check, restoring divisions for the segment
// fraction and the final curve parameter, all on one shared adder.
// ----------------------------------------------------------------------------
module alrp_seq #(
    parameter int MAX_ENTRIES = alrp_pkg::MAX_ENTRIES_DEF,
    parameter int LENGTH_BITS = alrp_pkg::LENGTH_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [alrp_pkg::POS_W-1:0]      position,
    input  alrp_pkg::cfg_t                  cfg,
    output logic                            rd_en,
    output logic [$clog2(MAX_ENTRIES)-1:0]  rd_addr,
    input  logic [LENGTH_BITS-1:0]          rd_data,
    output alrp_pkg::seq_status_t           status,
    output alrp_pkg::res_t                  res,
    input  logic                            res_ack
);

    localparam int L      = LENGTH_BITS;
    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int DIV_W  = (IDX_W < alrp_pkg::DIVISIONS_W) ? IDX_W : alrp_pkg::DIVISIONS_W;
    localparam int AW     = LENGTH_BITS + 2;
    localparam int QW     = alrp_pkg::POS_W;
    localparam int NUM_W  = DIV_W + QW;
    localparam int SW     = alrp_pkg::STEP_W;

    // Sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_LAST_RD = 5'd1;
    localparam logic [4:0] S_LAST    = 5'd2;
    localparam logic [4:0] S_MUL     = 5'd3;
    localparam logic [4:0] S_TGT     = 5'd4;
    localparam logic [4:0] S_SRD     = 5'd5;
    localparam logic [4:0] S_SCMP    = 5'd6;
    localparam logic [4:0] S_BRD     = 5'd7;
    localparam logic [4:0] S_BEF     = 5'd8;
    localparam logic [4:0] S_DIF     = 5'd9;
    localparam logic [4:0] S_TOL     = 5'd10;
    localparam logic [4:0] S_ARD     = 5'd11;
    localparam logic [4:0] S_SEG     = 5'd12;
    localparam logic [4:0] S_NCMP    = 5'd13;
    localparam logic [4:0] S_FDIV    = 5'd14;
    localparam logic [4:0] S_QINIT   = 5'd15;
    localparam logic [4:0] S_QDIV    = 5'd16;
    localparam logic [4:0] S_DONE    = 5'd17;

    logic [4:0]       state_reg, state_next;
    logic [SW-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0] d_reg, d_next;
    logic [L-1:0]     last_reg, last_next;
    logic [AW-2:0]    acc_reg, acc_next;
    logic [QW-1:0]    lo_reg, lo_next;
    logic [L-1:0]     target_reg, target_next;
    logic [CNT_W-1:0] low_reg, low_next;
    logic [CNT_W-1:0] hp1_reg, hp1_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [L-1:0]     before_reg, before_next;
    logic [L-1:0]     num_reg, num_next;
    logic [L-1:0]     seg_reg, seg_next;
    logic [QW-1:0]    frac_reg, frac_next;
    logic             ge_reg, ge_next;
    logic             exact_reg, exact_next;

    logic             alu_op;
    logic [AW-1:0]    alu_a, alu_b, alu_sum;
    logic             alu_neg, alu_zero;

    logic [IDX_W-1:0] d_eff;
    logic [QW-1:0]    u_clamped;
    logic [CNT_W-1:0] span, mid_w;
    logic [IDX_W-1:0] mid;
    logic [NUM_W-1:0] numer;
    logic [DIV_W:0]   qtrial;
    logic             found;

    alrp_alu #(
        .W (AW)
    ) u_alu (
        .op   (alu_op),
        .a    (alu_a),
        .b    (alu_b),
        .sum  (alu_sum),
        .neg  (alu_neg),
        .zero (alu_zero)
    );

    // Effective division count and clamped position
    always_comb
    begin
        if (cfg.divisions == '0)
        begin
            d_eff = IDX_W'(1);
        end
        else if (32'(cfg.divisions) > 32'(MAX_ENTRIES - 1))
        begin
            d_eff = IDX_W'(MAX_ENTRIES - 1);
        end
        else
        begin
            d_eff = IDX_W'(cfg.divisions);
        end
        u_clamped = (position > alrp_pkg::ONE_Q16) ? alrp_pkg::ONE_Q16 : position;
    end

    // Search midpoint, final-divide numerator and trial remainder
    always_comb
    begin
        span   = hp1_reg - low_reg - CNT_W'(1);
        mid_w  = low_reg + (span >> 1);
        mid    = IDX_W'(mid_w);
        numer  = NUM_W'({i_reg[DIV_W-1:0], {alrp_pkg::FRAC_BITS{1'b0}}}) + NUM_W'(frac_reg);
        qtrial = {acc_reg[DIV_W-1:0], lo_reg[QW-1]};
    end

    // Operand select for the shared adder
    always_comb
    begin
        alu_op = alrp_pkg::ALU_SUB;
        alu_a  = '0;
        alu_b  = '0;
        case (state_reg)
            S_MUL:
            begin
                alu_op = alrp_pkg::ALU_ADD;
                alu_a  = AW'(acc_reg[L-1:0]);
                alu_b  = lo_reg[0] ? AW'(last_reg) : '0;
            end
            S_SCMP, S_BEF:
            begin
                alu_a = AW'(rd_data);
                alu_b = AW'(target_reg);
            end
            S_DIF:
            begin
                alu_a = AW'(target_reg);
                alu_b = AW'(before_reg);
            end
            S_TOL:
            begin
                alu_a = AW'(acc_reg);
                alu_b = AW'(cfg.match_tolerance);
            end
            S_SEG:
            begin
                alu_a = AW'(rd_data);
                alu_b = AW'(before_reg);
            end
            S_NCMP:
            begin
                alu_a = AW'(num_reg);
                alu_b = AW'(seg_reg);
            end
            S_FDIV:
            begin
                alu_a = {acc_reg, 1'b0};
                alu_b = AW'(seg_reg);
            end
            S_QDIV:
            begin
                alu_a = AW'(qtrial);
                alu_b = AW'(d_reg);
            end
            default: ;
        endcase
    end

    // Sequencer next-state and datapath updates
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        d_next      = d_reg;
        last_next   = last_reg;
        acc_next    = acc_reg;
        lo_next     = lo_reg;
        target_next = target_reg;
        low_next    = low_reg;
        hp1_next    = hp1_reg;
        i_next      = i_reg;
        before_next = before_reg;
        num_next    = num_reg;
        seg_next    = seg_reg;
        frac_next   = frac_reg;
        ge_next     = ge_reg;
        exact_next  = exact_reg;
        found       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    d_next     = d_eff;
                    lo_next    = u_clamped;
                    state_next = S_LAST_RD;
                end
            end
            S_LAST_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = d_reg;
                state_next = S_LAST;
            end
            S_LAST:
            begin
                last_next  = rd_data;
                acc_next   = '0;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            // LSB-first shift-add: {acc, lo} ends as u * last
            S_MUL:
            begin
                acc_next = (AW-1)'(alu_sum[L:1]);
                lo_next  = {alu_sum[0], lo_reg[QW-1:1]};
                cnt_next = cnt_reg + SW'(1);
                if (cnt_reg == SW'(alrp_pkg::MUL_STEPS - 1))
                begin
                    state_next = S_TGT;
                end
            end
            S_TGT:
            begin
                target_next = {acc_reg[L-2:0], lo_reg[QW-1]};
                low_next    = '0;
                hp1_next    = CNT_W'(d_reg) + CNT_W'(1);
                state_next  = S_SRD;
            end
            S_SRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = mid;
                state_next = S_SCMP;
            end
            // hp1 holds high + 1, so an empty range is low >= hp1
            S_SCMP:
            begin
                if (alu_neg)
                begin
                    low_next = mid_w + CNT_W'(1);
                end
                else if (alu_zero)
                begin
                    hp1_next = mid_w + CNT_W'(1);
                    found    = 1'b1;
                end
                else
                begin
                    hp1_next = mid_w;
                end
                if (found || (low_next >= hp1_next))
                begin
                    i_next     = (hp1_next == '0) ? '0 : IDX_W'(hp1_next - CNT_W'(1));
                    state_next = S_BRD;
                end
                else
                begin
                    state_next = S_SRD;
                end
            end
            S_BRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = i_reg;
                state_next = S_BEF;
            end
            S_BEF:
            begin
                before_next = rd_data;
                acc_next    = (AW-1)'(alu_sum);
                ge_next     = !alu_neg;
                state_next  = S_DIF;
            end
            // Absolute distance; also keeps target - before
            S_DIF:
            begin
                num_next = L'(alu_sum);
                if (!ge_reg)
                begin
                    acc_next = (AW-1)'(alu_sum);
                end
                state_next = S_TOL;
            end
            S_TOL:
            begin
                if (alu_neg)
                begin
                    exact_next = 1'b1;
                    frac_next  = '0;
                    state_next = S_QINIT;
                end
                else
                begin
                    exact_next = 1'b0;
                    if (!ge_reg && (i_reg < d_reg))
                    begin
                        state_next = S_ARD;
                    end
                    else
                    begin
                        frac_next  = '0;
                        state_next = S_QINIT;
                    end
                end
            end
            S_ARD:
            begin
                rd_en      = 1'b1;
                rd_addr    = i_reg + IDX_W'(1);
                state_next = S_SEG;
            end
            // Empty or reversed segment gives a zero fraction
            S_SEG:
            begin
                seg_next = L'(alu_sum);
                if (alu_neg || alu_zero)
                begin
                    frac_next  = '0;
                    state_next = S_QINIT;
                end
                else
                begin
                    state_next = S_NCMP;
                end
            end
            S_NCMP:
            begin
                if (!alu_neg)
                begin
                    frac_next  = alrp_pkg::ONE_Q16;
                    state_next = S_QINIT;
                end
                else
                begin
                    acc_next   = (AW-1)'(num_reg);
                    lo_next    = '0;
                    cnt_next   = '0;
                    state_next = S_FDIV;
                end
            end
            // Restoring divide: (num << 16) / seg, num < seg
            S_FDIV:
            begin
                if (!alu_neg)
                begin
                    acc_next = (AW-1)'(alu_sum);
                end
                else
                begin
                    acc_next = (AW-1)'({acc_reg, 1'b0});
                end
                lo_next  = {lo_reg[QW-2:0], !alu_neg};
                cnt_next = cnt_reg + SW'(1);
                if (cnt_reg == SW'(alrp_pkg::FDIV_STEPS - 1))
                begin
                    frac_next  = {1'b0, lo_next[alrp_pkg::FRAC_BITS-1:0]};
                    state_next = S_QINIT;
                end
            end
            // Quotient fits 17 bits, so the top part starts below d
            S_QINIT:
            begin
                acc_next   = (AW-1)'(numer[NUM_W-1:QW]);
                lo_next    = numer[QW-1:0];
                cnt_next   = '0;
                state_next = S_QDIV;
            end
            S_QDIV:
            begin
                if (!alu_neg)
                begin
                    acc_next = (AW-1)'(alu_sum[DIV_W-1:0]);
                end
                else
                begin
                    acc_next = (AW-1)'(qtrial[DIV_W-1:0]);
                end
                lo_next  = {lo_reg[QW-2:0], !alu_neg};
                cnt_next = cnt_reg + SW'(1);
                if (cnt_reg == SW'(alrp_pkg::QDIV_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        d_reg      <= d_next;
        last_reg   <= last_next;
        acc_reg    <= acc_next;
        lo_reg     <= lo_next;
        target_reg <= target_next;
        low_reg    <= low_next;
        hp1_reg    <= hp1_next;
        i_reg      <= i_next;
        before_reg <= before_next;
        num_reg    <= num_next;
        seg_reg    <= seg_next;
        frac_reg   <= frac_next;
        ge_reg     <= ge_next;
        exact_reg  <= exact_next;
    end

    assign status.idle     = (state_reg == S_IDLE);
    assign status.done     = (state_reg == S_DONE);
    assign res.curve_param = lo_reg;
    assign res.exact_hit   = exact_reg;

endmodule

/* rtl/core/alrp_checker.sv */
// ----------------------------------------------------------------------------
// alrp_checker
// Port-level checks for the arc-length reparameterization block, attached
// to the top level by bind.
// ----------------------------------------------------------------------------
module alrp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cmd_valid,
    input logic                           cmd_ready,
    input logic [alrp_pkg::CMD_W-1:0]     cmd_command,
    input logic                           res_valid,
    input logic                           res_ready,
    input logic [alrp_pkg::POS_W-1:0]     res_curve_param,
    input logic                           res_exact_hit
);

    // Result held while the receiver stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped during stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_curve_param) && $stable(res_exact_hit))
        else $error("result payload changed during stall");

    // A query occupies the sequencer for the following cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_command == alrp_pkg::CMD_MAP) |=> !cmd_ready)
        else $error("command taken right after a query transfer");

    // Curve parameter never exceeds 1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_curve_param <= alrp_pkg::ONE_Q16))
        else $error("curve parameter above 1.0");

    // No result while reset is applied
    assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result valid during reset");

endmodule

bind arc_length_reparameterize alrp_checker u_alrp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .cmd_command     (cmd.command),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_curve_param (result.curve_param),
    .res_exact_hit   (result.exact_hit)
);
